// ===== rtl/ist_pkg.sv =====
// shared types and constants for the integer set table
// no dependencies; used by ist_seq and integer_set_table
package ist_pkg;

    localparam int CAPACITY    = 16;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [VAL_W-1:0]       t_val;
    typedef logic [OP_W-1:0]        t_op;
    typedef logic [COUNT_OUT_W-1:0] t_cnt_out;

    localparam t_op  OP_ADD      = 2'd0;
    localparam t_op  OP_REMOVE   = 2'd1;
    localparam t_op  OP_CONTAINS = 2'd2;

    localparam t_cnt CAP_CNT = t_cnt'(CAPACITY);

    // table memory access from the sequencer
    typedef struct packed {
        logic we;
        t_idx waddr;
        t_val wdata;
        t_idx raddr;
    } t_ram_req;

    // end-of-operation report to the count and result registers
    typedef struct packed {
        logic valid;
        logic found;
        logic full;
        logic inc;
        logic dec;
    } t_upd;

endpackage

// ===== rtl/ist_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ist_seq.sv =====
// sequencer for the integer set table: scan, shift-down and finish steps
// with one shared equality compare; depends on ist_pkg
module ist_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ist_pkg::t_op      i_opcode,
    input  ist_pkg::t_val     i_value,
    input  ist_pkg::t_cnt     i_count,
    input  ist_pkg::t_val     i_rdata,
    output logic              o_busy,
    output ist_pkg::t_ram_req o_ram,
    output ist_pkg::t_upd     o_upd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    ist_pkg::t_op  r_op, n_op;
    ist_pkg::t_val r_value, n_value;
    ist_pkg::t_cnt r_idx, n_idx;
    ist_pkg::t_cnt r_pend_idx, n_pend_idx;
    logic          r_pend, n_pend;
    logic          r_hit, n_hit;

    logic          w_match;
    logic          w_last;
    logic          w_more;
    logic          w_is_add;
    logic          w_is_rem;
    ist_pkg::t_cnt w_prev_idx;
    ist_pkg::t_cnt w_last_idx;

    assign w_is_add   = (r_op == ist_pkg::OP_ADD);
    assign w_is_rem   = (r_op == ist_pkg::OP_REMOVE);
    // shared compare unit
    assign w_match    = r_pend && (i_rdata == r_value);
    assign w_last_idx = i_count - ist_pkg::t_cnt'(1);
    assign w_last     = r_pend && (r_pend_idx == w_last_idx);
    assign w_more     = (r_idx < i_count);
    assign w_prev_idx = r_pend_idx - ist_pkg::t_cnt'(1);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_value    = r_value;
        n_idx      = r_idx;
        n_pend_idx = r_pend_idx;
        n_pend     = r_pend;
        n_hit      = r_hit;
        o_ram      = '0;
        o_ram.raddr = r_idx[ist_pkg::IDX_W-1:0];
        o_upd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_value = i_value;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_hit   = 1'b0;
                    n_state = (i_count == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend     = w_more;
                n_pend_idx = r_idx;
                if (w_more) begin
                    n_idx = r_idx + ist_pkg::t_cnt'(1);
                end
                if (w_match) begin
                    n_hit = 1'b1;
                    if (w_is_rem) begin
                        n_idx   = r_pend_idx + ist_pkg::t_cnt'(1);
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                // read entry idx, write it one place down in the following cycle
                o_ram.we    = r_pend;
                o_ram.waddr = w_prev_idx[ist_pkg::IDX_W-1:0];
                o_ram.wdata = i_rdata;
                n_pend      = w_more;
                n_pend_idx  = r_idx;
                if (w_more) begin
                    n_idx = r_idx + ist_pkg::t_cnt'(1);
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_upd.valid = 1'b1;
                o_upd.found = r_hit;
                o_upd.full  = w_is_add && !r_hit && (i_count == ist_pkg::CAP_CNT);
                o_upd.inc   = w_is_add && !r_hit && (i_count != ist_pkg::CAP_CNT);
                o_upd.dec   = w_is_rem && r_hit;
                o_ram.we    = o_upd.inc;
                o_ram.waddr = i_count[ist_pkg::IDX_W-1:0];
                o_ram.wdata = r_value;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_op       <= n_op;
        r_value    <= n_value;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_hit      <= n_hit;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/integer_set_table.sv =====
// top level of the integer set table: element count, result registers,
// table memory and sequencer; depends on ist_pkg, ist_ram and ist_seq
//
//  channel   | transfer marked by       | fields
//  ----------+--------------------------+------------------------------
//  command   | start high, busy low     | i_opcode, i_value
//  result    | o_done high, one cycle   | o_found, o_full_res, o_count
//
// scan: an operation walks the held entries through one memory read port,
//   one entry per cycle with one compare; a remove of a present value stops the
//   scan at the hit and moves the later entries down one per cycle
// busy stays high from the transfer until the cycle in which o_done shows
// reset: synchronous active-low reset empties the set; table contents are
//   left as they are and are only read after being written
// the receiver cannot stall: each result is shown for exactly one cycle
module integer_set_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_opcode,
    input  logic signed [31:0]    i_value,
    output logic                  busy,
    output logic                  o_done,
    output logic                  o_found,
    output logic                  o_full_res,
    output logic [4:0]            o_count
);

    // element count and result registers
    ist_pkg::t_cnt     r_count, n_count;
    logic              r_done;
    logic              r_found;
    logic              r_full;

    ist_pkg::t_ram_req w_ram;
    ist_pkg::t_upd     w_upd;
    ist_pkg::t_val     w_rdata;
    logic              w_busy;

    // entries of the set, write and read port shared over the sequence
    ist_ram #(
        .WIDTH (ist_pkg::VAL_W),
        .DEPTH (ist_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // scan / shift / finish sequencer
    ist_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_value  (ist_pkg::t_val'(i_value)),
        .i_count  (r_count),
        .i_rdata  (w_rdata),
        .o_busy   (w_busy),
        .o_ram    (w_ram),
        .o_upd    (w_upd)
    );

    // count follows the finish step of each operation
    always_comb begin
        n_count = r_count;
        if (w_upd.inc) begin
            n_count = r_count + ist_pkg::t_cnt'(1);
        end else if (w_upd.dec) begin
            n_count = r_count - ist_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_upd.valid;
        end
        r_found <= w_upd.found;
        r_full  <= w_upd.full;
    end

    assign busy       = w_busy;
    assign o_done     = r_done;
    assign o_found    = r_found;
    assign o_full_res = r_full;
    // count is at most 16 and fits the 5-bit output as it is; it would wrap modulo 32 only for a capacity of 32 or more
    assign o_count    = ist_pkg::t_cnt_out'(r_count);

    // the set never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ist_pkg::CAP_CNT)
        else $error("element count above capacity");

    // an accepted command keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // a result only appears once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // a rejected add leaves a full table and never reports a hit
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_full_res) |-> (r_count == ist_pkg::CAP_CNT && !o_found))
        else $error("full flag without a full table");

endmodule
